// ----- rtl/rbd_pkg.sv -----
`default_nettype none
package rbd_pkg;

  localparam int NUM_LANES = 4;
  localparam int CHAN_W    = 16;
  localparam int COORD_W   = 12;
  localparam int SCALE_W   = 7;
  localparam int SIZE_W    = 13;
  localparam int BUDGET_W  = 11;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_W = 2'd0,
    REG_REGION_H = 2'd1,
    REG_MAX_OUT_W = 2'd2,
    REG_MAX_OUT_H = 2'd3
  } cfg_reg_t;

  // Per-pixel control that the sequencer hands to every channel lane.
  typedef struct packed {
    logic rd_en;
    logic acc_en;
    logic band_first;
    logic band_last;
    logic cell_first;
    logic div_start;
  } lane_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/rbd_if.sv -----
`default_nettype none
interface rbd_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;
  logic [15:0] alpha_in;
  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface rbd_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_avg;
  logic [15:0] green_avg;
  logic [15:0] blue_avg;
  logic [15:0] alpha_avg;
  logic [11:0] out_col;
  logic [11:0] out_row;
  logic [6:0]  scale_used;
  logic        scale_clamped;
  logic        frame_last;
  modport source (output valid, red_avg, green_avg, blue_avg, alpha_avg, out_col, out_row,
                  scale_used, scale_clamped, frame_last, input ready);
  modport sink   (input valid, red_avg, green_avg, blue_avg, alpha_avg, out_col, out_row,
                  scale_used, scale_clamped, frame_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/rbd_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module rbd_div #(
  parameter int NW = 16,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [NW-1:0]    num_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    den_r;
  logic [DW:0]      trial;
  logic             ge;

  assign trial = {rem_r, num_r[NW-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      num_r <= {num_r[NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = num_r;
endmodule
`default_nettype wire

// ----- rtl/rbd_lane.sv -----
`default_nettype none
// One color channel: column-sum line store, cell accumulator and divider.
module rbd_lane #(
  parameter int DEPTH = 4096,
  parameter int COLW  = 22,
  parameter int SUMW  = 28,
  parameter int CNTW  = 14,
  parameter int PIXW  = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire rbd_pkg::lane_ctl_t       ctl,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [PIXW-1:0]          pix,
  input  wire logic [CNTW-1:0]          cnt,
  output logic                          done,
  output logic [15:0]                   avg
);
  import rbd_pkg::*;

  logic [COLW-1:0] mem [DEPTH];
  logic [COLW-1:0] rd_r;
  logic [PIXW-1:0] pix_r;
  logic [SUMW-1:0] cell_r;
  logic [COLW-1:0] col;
  logic [SUMW-1:0] quo;

  assign col = ctl.band_first ? COLW'(pix_r) : rd_r + COLW'(pix_r);

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      pix_r <= pix;
      rd_r  <= mem[addr];
    end
    if (ctl.acc_en) begin
      mem[addr] <= col;
      if (ctl.band_last) begin
        cell_r <= ctl.cell_first ? SUMW'(col) : cell_r + SUMW'(col);
      end
    end
  end

  rbd_div #(.NW(SUMW), .DW(CNTW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctl.div_start),
    .num   (cell_r + SUMW'(cnt >> 1)),
    .den   (cnt),
    .done  (done),
    .quo   (quo)
  );

  assign avg = 16'(quo);
endmodule
`default_nettype wire

// ----- rtl/region_box_downsampler.sv -----
`default_nettype none
// Channel   Dir  Handshake        Payload
// in_ch     in   valid / ready    red_in, green_in, blue_in, alpha_in
// out_ch    out  valid / ready    four channel means, cell position, scale, flags
// cfg_*     in   cfg_we only      cfg_index selects the register, cfg_data the value
//
// Each pixel item is read from the line store in S_RUN and added and written
// back in S_ACC. An item that closes a cell then passes S_START, which starts
// the lane dividers, S_DIV, which waits for the division, and S_OUT, which loads
// the output register and stretches while the previous result is not taken.
// The first item of a region waits while S_IDLE latches the size and S_SCALE
// runs the scale divide. Reset is synchronous; the line stores are not cleared.
module region_box_downsampler #(
  parameter int MAX_REGION_W = 4096,
  parameter int MAX_SCALE    = 64,
  parameter int CHANNEL_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  rbd_pix_if.sink                              in_ch,
  rbd_res_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [rbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rbd_pkg::SIZE_W-1:0]      cfg_data
);
  import rbd_pkg::*;

  // Widths that follow from the parameters.
  localparam int XIW   = $clog2(MAX_REGION_W);       // pixel index
  localparam int XW    = $clog2(MAX_REGION_W + 1);   // latched size
  localparam int CMPW  = (XW > SIZE_W) ? XW : SIZE_W;
  localparam int NUMW  = ((XW > BUDGET_W) ? XW : BUDGET_W) + 1;
  localparam int SCW   = $clog2(MAX_SCALE + 1);
  localparam int LOGS  = $clog2(MAX_SCALE);
  localparam int COLW  = CHANNEL_BITS + LOGS;
  localparam int SUMW  = CHANNEL_BITS + 2 * LOGS;
  localparam int CNTW  = 2 * SCW;

  typedef enum logic [2:0] {
    S_IDLE, S_SCALE, S_RUN, S_ACC, S_START, S_DIV, S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [SIZE_W-1:0]   reg_w_r, reg_h_r;
  logic [BUDGET_W-1:0] reg_mw_r, reg_mh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_w_r  <= SIZE_W'(1);
      reg_h_r  <= SIZE_W'(1);
      reg_mw_r <= BUDGET_W'(1024);
      reg_mh_r <= BUDGET_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REGION_W:  reg_w_r  <= cfg_data;
        REG_REGION_H:  reg_h_r  <= cfg_data;
        REG_MAX_OUT_W: reg_mw_r <= cfg_data[BUDGET_W-1:0];
        REG_MAX_OUT_H: reg_mh_r <= cfg_data[BUDGET_W-1:0];
        default: ;
      endcase
    end
  end

  // Region size with zero raised to one and oversize saturated.
  function automatic logic [XW-1:0] size_fix(input logic [SIZE_W-1:0] v);
    logic [CMPW-1:0] e;
    e = CMPW'(v);
    if (e == '0) return XW'(1);
    if (e > CMPW'(MAX_REGION_W)) return XW'(MAX_REGION_W);
    return XW'(e);
  endfunction

  logic [XW-1:0]       fix_w, fix_h;
  logic [BUDGET_W-1:0] mw, mh;
  logic [NUMW-1:0]     qx, qy, qmax;
  logic                sx_done, sy_done, scale_go;

  assign fix_w = size_fix(reg_w_r);
  assign fix_h = size_fix(reg_h_r);
  assign mw    = (reg_mw_r == '0) ? BUDGET_W'(1) : reg_mw_r;
  assign mh    = (reg_mh_r == '0) ? BUDGET_W'(1) : reg_mh_r;
  assign scale_go = (state_r == S_IDLE) && in_ch.valid;
  assign qmax  = (qx > qy) ? qx : qy;

  // The horizontal and vertical ceiling divisions run side by side.
  rbd_div #(.NW(NUMW), .DW(BUDGET_W)) u_sx (
    .clk (clk), .rst_n (rst_n), .start (scale_go),
    .num (NUMW'(fix_w) + NUMW'(mw) - NUMW'(1)), .den (mw),
    .done (sx_done), .quo (qx)
  );
  rbd_div #(.NW(NUMW), .DW(BUDGET_W)) u_sy (
    .clk (clk), .rst_n (rst_n), .start (scale_go),
    .num (NUMW'(fix_h) + NUMW'(mh) - NUMW'(1)), .den (mh),
    .done (sy_done), .quo (qy)
  );

  // Region position: pixel counters plus the place inside the current cell.
  logic [XW-1:0]    lat_w_r, lat_h_r;
  logic [SCW-1:0]   scale_r;
  logic             clamp_r;
  logic [XIW-1:0]   px_r, py_r, cellx_r, celly_r;
  logic [SCW-1:0]   colc_r, rowc_r;
  logic [CNTW-1:0]  cnt_r;
  logic             fend_r;
  logic [COORD_W-1:0] ocol_r, orow_r;

  logic band_first, band_last, cell_last, row_end, frame_end, emit;

  assign band_first = (rowc_r == '0);
  assign row_end    = (XW'(px_r) == lat_w_r - XW'(1));
  assign band_last  = (rowc_r == scale_r - SCW'(1)) || (XW'(py_r) == lat_h_r - XW'(1));
  assign cell_last  = (colc_r == scale_r - SCW'(1)) || row_end;
  assign frame_end  = row_end && (XW'(py_r) == lat_h_r - XW'(1));
  assign emit       = band_last && cell_last;

  // Lanes.
  lane_ctl_t ctl;
  logic [NUM_LANES-1:0] lane_done;
  logic [15:0] avg [NUM_LANES];
  logic [15:0] pix [NUM_LANES];
  logic out_free;

  assign pix[0] = in_ch.red_in;
  assign pix[1] = in_ch.green_in;
  assign pix[2] = in_ch.blue_in;
  assign pix[3] = in_ch.alpha_in;

  assign in_ch.ready    = (state_r == S_RUN);
  assign ctl.rd_en      = in_ch.valid && in_ch.ready;
  assign ctl.acc_en     = (state_r == S_ACC);
  assign ctl.band_first = band_first;
  assign ctl.band_last  = band_last;
  assign ctl.cell_first = (colc_r == '0);
  assign ctl.div_start  = (state_r == S_START);

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    rbd_lane #(
      .DEPTH (MAX_REGION_W), .COLW (COLW), .SUMW (SUMW), .CNTW (CNTW),
      .PIXW (CHANNEL_BITS)
    ) u_lane (
      .clk  (clk),
      .rst_n (rst_n),
      .ctl  (ctl),
      .addr (px_r),
      .pix  (CHANNEL_BITS'(pix[i])),
      .cnt  (cnt_r),
      .done (lane_done[i]),
      .avg  (avg[i])
    );
  end

  // The output register frees up when its item is taken.
  logic out_valid_r;
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      px_r        <= '0;
      py_r        <= '0;
      cellx_r     <= '0;
      celly_r     <= '0;
      colc_r      <= '0;
      rowc_r      <= '0;
      scale_r     <= SCW'(1);
      clamp_r     <= 1'b0;
      lat_w_r     <= XW'(1);
      lat_h_r     <= XW'(1);
      fend_r      <= 1'b0;
    end else begin
      // In S_OUT a taken item is replaced by the new one below.
      if (out_ch.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            lat_w_r <= fix_w;
            lat_h_r <= fix_h;
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          // A register write during the scale divide restarts it.
          if (cfg_we) begin
            state_r <= S_IDLE;
          end else if (sx_done && sy_done) begin
            if (qmax > NUMW'(MAX_SCALE)) begin
              scale_r <= SCW'(MAX_SCALE);
              clamp_r <= 1'b1;
            end else begin
              scale_r <= (qmax == '0) ? SCW'(1) : SCW'(qmax);
              clamp_r <= 1'b0;
            end
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (in_ch.valid) state_r <= S_ACC;
        end
        S_ACC: begin
          cnt_r  <= CNTW'(colc_r + SCW'(1)) * CNTW'(rowc_r + SCW'(1));
          ocol_r <= COORD_W'(cellx_r);
          orow_r <= COORD_W'(celly_r);
          fend_r <= frame_end;
          if (frame_end) begin
            px_r    <= '0;
            py_r    <= '0;
            colc_r  <= '0;
            rowc_r  <= '0;
            cellx_r <= '0;
            celly_r <= '0;
          end else if (row_end) begin
            px_r    <= '0;
            colc_r  <= '0;
            cellx_r <= '0;
            py_r    <= py_r + 1'b1;
            if (rowc_r == scale_r - SCW'(1)) begin
              rowc_r  <= '0;
              celly_r <= celly_r + 1'b1;
            end else begin
              rowc_r <= rowc_r + 1'b1;
            end
          end else begin
            px_r <= px_r + 1'b1;
            if (colc_r == scale_r - SCW'(1)) begin
              colc_r  <= '0;
              cellx_r <= cellx_r + 1'b1;
            end else begin
              colc_r <= colc_r + 1'b1;
            end
          end
          state_r <= emit ? S_START : S_RUN;
        end
        S_START: state_r <= S_DIV;
        S_DIV: begin
          if (&lane_done) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= fend_r ? S_IDLE : S_RUN;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result payload, loaded together with out_valid_r.
  logic [15:0] avg_r [NUM_LANES];
  logic [COORD_W-1:0] col_r, row_r;
  logic [SCALE_W-1:0] sc_r;
  logic clamp_o_r, last_o_r;

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      for (int i = 0; i < NUM_LANES; i++) avg_r[i] <= avg[i];
      col_r     <= ocol_r;
      row_r     <= orow_r;
      sc_r      <= SCALE_W'(scale_r);
      clamp_o_r <= clamp_r;
      last_o_r  <= fend_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.red_avg       = avg_r[0];
  assign out_ch.green_avg     = avg_r[1];
  assign out_ch.blue_avg      = avg_r[2];
  assign out_ch.alpha_avg     = avg_r[3];
  assign out_ch.out_col       = col_r;
  assign out_ch.out_row       = row_r;
  assign out_ch.scale_used    = sc_r;
  assign out_ch.scale_clamped = clamp_o_r;
  assign out_ch.frame_last    = last_o_r;
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import rbd_pkg::*;

  localparam int REGION_MAX  = 4096;
  localparam int SCALE_MAX   = 64;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE      = 200;

  // One output pixel of the reduced image, as the block reports it.
  typedef struct {
    logic [CHAN_W-1:0]  chan [NUM_LANES];
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [SCALE_W-1:0] scale;
    logic               clamped;
    logic               last;
  } cell_t;

  // Mirrors the block's region and line-store state and keeps the cell means
  // that are still owed by the block.
  class cell_scoreboard;
    cell_t       owed [$];
    int          errors;
    int          reg_val [4];
    longint      col_sum [NUM_LANES][REGION_MAX];
    int          px, py, scale, lat_w, lat_h;
    bit          clamp;

    function new();
      errors     = 0;
      reg_val[REG_REGION_W]  = 1;
      reg_val[REG_REGION_H]  = 1;
      reg_val[REG_MAX_OUT_W] = 1024;
      reg_val[REG_MAX_OUT_H] = 1024;
      px = 0; py = 0; scale = 1; lat_w = 1; lat_h = 1; clamp = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, int value);
      reg_val[idx] = (idx == REG_MAX_OUT_W || idx == REG_MAX_OUT_H) ? value & 'h7ff
                                                                      : value & 'h1fff;
    endfunction

    function int fix_size(int v);
      return (v == 0) ? 1 : (v > REGION_MAX ? REGION_MAX : v);
    endfunction

    // Called for every accepted input item; queues the cell mean it closes.
    function void note_pixel(logic [CHAN_W-1:0] pix [NUM_LANES]);
      int mw, mh, sx, sy, x0, rows, n;
      bit band_first, band_last, cell_last, frame_end;
      longint sum;
      cell_t c;
      if (px == 0 && py == 0) begin
        // A new region latches its size and derives the scale.
        mw    = reg_val[REG_MAX_OUT_W] == 0 ? 1 : reg_val[REG_MAX_OUT_W];
        mh    = reg_val[REG_MAX_OUT_H] == 0 ? 1 : reg_val[REG_MAX_OUT_H];
        lat_w = fix_size(reg_val[REG_REGION_W]);
        lat_h = fix_size(reg_val[REG_REGION_H]);
        sx    = (lat_w + mw - 1) / mw;
        sy    = (lat_h + mh - 1) / mh;
        scale = sx > sy ? sx : sy;
        if (scale < 1) scale = 1;
        clamp = scale > SCALE_MAX;
        if (clamp) scale = SCALE_MAX;
      end
      band_first = (py % scale) == 0;
      band_last  = ((py % scale) == scale - 1) || (py == lat_h - 1);
      cell_last  = ((px % scale) == scale - 1) || (px == lat_w - 1);
      frame_end  = (px == lat_w - 1) && (py == lat_h - 1);
      for (int k = 0; k < NUM_LANES; k++)
        col_sum[k][px] = band_first ? longint'(pix[k]) : col_sum[k][px] + pix[k];
      if (band_last && cell_last) begin
        x0   = px - (px % scale);
        rows = (py % scale) + 1;
        n    = (px - x0 + 1) * rows;
        for (int k = 0; k < NUM_LANES; k++) begin
          sum = 0;
          for (int j = x0; j <= px; j++) sum += col_sum[k][j];
          c.chan[k] = CHAN_W'((sum + n / 2) / n);
        end
        c.col     = COORD_W'(px / scale);
        c.row     = COORD_W'(py / scale);
        c.scale   = SCALE_W'(scale);
        c.clamped = clamp;
        c.last    = frame_end;
        owed.push_back(c);
      end
      if (frame_end) begin
        px = 0; py = 0;
      end else if (px >= lat_w - 1) begin
        px = 0; py = py + 1;
      end else begin
        px = px + 1;
      end
    endfunction

    function void compare(string field, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_cell(cell_t got);
      cell_t want;
      if (owed.size() == 0) begin
        $error("output item with nothing expected (col %0d row %0d)", got.col, got.row);
        errors++;
        return;
      end
      want = owed.pop_front();
      compare("red_avg",       want.chan[0], got.chan[0]);
      compare("green_avg",     want.chan[1], got.chan[1]);
      compare("blue_avg",      want.chan[2], got.chan[2]);
      compare("alpha_avg",     want.chan[3], got.chan[3]);
      compare("out_col",       want.col,     got.col);
      compare("out_row",       want.row,     got.row);
      compare("scale_used",    want.scale,   got.scale);
      compare("scale_clamped", want.clamped, got.clamped);
      compare("frame_last",    want.last,    got.last);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  rbd_pix_if pix_ch ();
  rbd_res_if res_ch ();

  region_box_downsampler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (pix_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cell_scoreboard sb = new();
  int burst_left = 0;
  int cycles     = 0;
  int sent       = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The run is stopped hard if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Receiver: the stall pattern is redrawn at random between always ready,
  // about half ready, and mostly stalled, so back-pressure lands on every
  // phase of the divider and output register.
  int stall_mode = 0;
  always @(posedge clk) begin
    cell_t got;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.chan[0] = res_ch.red_avg;
        got.chan[1] = res_ch.green_avg;
        got.chan[2] = res_ch.blue_avg;
        got.chan[3] = res_ch.alpha_avg;
        got.col     = res_ch.out_col;
        got.row     = res_ch.out_row;
        got.scale   = res_ch.scale_used;
        got.clamped = res_ch.scale_clamped;
        got.last    = res_ch.frame_last;
        sb.check_cell(got);
      end
      if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: begin
          res_ch.ready <= 1'b1;
        end
        1: begin
          res_ch.ready <= $urandom_range(0, 1);
        end
        default: begin
          res_ch.ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // Writes one register; the caller lowers the write enable afterwards.
  task automatic write_reg(cfg_reg_t idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= SIZE_W'(value);
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic set_region(int w, int h, int mw, int mh);
    write_reg(REG_REGION_W, w);
    write_reg(REG_REGION_H, h);
    write_reg(REG_MAX_OUT_W, mw);
    write_reg(REG_MAX_OUT_H, mh);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one pixel item. Valid drops between bursts and stays high from item
  // to item within a burst.
  task automatic send_pixel(logic [CHAN_W-1:0] pix [NUM_LANES]);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.red_in   <= pix[0];
    pix_ch.green_in <= pix[1];
    pix_ch.blue_in  <= pix[2];
    pix_ch.alpha_in <= pix[3];
    do @(posedge clk); while (!pix_ch.ready);
    sb.note_pixel(pix);
    burst_left--;
    sent++;
  endtask

  function automatic logic [CHAN_W-1:0] pick_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  // Streams a whole region of random pixels, then holds off until the block
  // has delivered every owed cell, so the next register writes find it idle.
  task automatic run_region(int w, int h);
    logic [CHAN_W-1:0] pix [NUM_LANES];
    int total;
    total = sb.fix_size(w) * sb.fix_size(h);
    for (int i = 0; i < total; i++) begin
      for (int k = 0; k < NUM_LANES; k++) pix[k] = pick_channel();
      send_pixel(pix);
    end
    pix_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [CHAN_W-1:0] pix [NUM_LANES];
    int w, h;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    pix_ch.valid    = 1'b0;
    pix_ch.red_in   = '0;
    pix_ch.green_in = '0;
    pix_ch.blue_in  = '0;
    pix_ch.alpha_in = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: the 1x1 region left by reset, with full-scale channels.
    for (int k = 0; k < NUM_LANES; k++) pix[k] = '1;
    send_pixel(pix);
    pix_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    // Zero size and zero budget are both read as one.
    set_region(0, 0, 0, 0);
    run_region(0, 0);
    // Scale 2 with partial right and bottom cells.
    set_region(3, 3, 2, 1024);
    run_region(3, 3);
    // Scale 3 from the width budget, with a partial right cell.
    set_region(5, 2, 2, 1024);
    run_region(5, 2);
    // Scale 3 from the height budget, a single-column region.
    set_region(1, 7, 1024, 3);
    run_region(1, 7);

    // Extremes: a scale just over the limit, which clamps.
    set_region(65, 1, 1, 1024);
    run_region(65, 1);

    // Random regions of modest size with varied budgets.
    while (sent < 1000) begin
      w = $urandom_range(1, 24);
      h = $urandom_range(1, 12);
      case ($urandom_range(0, 7))
        0: set_region(w, h, 0, $urandom_range(0, 2047));
        1: set_region(w, h, $urandom_range(0, 2047), 1024);
        default: set_region(w, h, $urandom_range(1, 12), $urandom_range(1, 8));
      endcase
      run_region(w, h);
    end

    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
